[rtl/qpht_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types, widths and constants of the quadratic probing hash table.
// ----------------------------------------------------------------------------
package qpht_pkg;

    localparam int DEF_TABLE_SLOTS = 1024;

    localparam int ACTION_W    = 2;
    localparam int KEY_W       = 31;
    localparam int STATUS_W    = 3;
    localparam int SLOT_IDX_W  = 10;
    localparam int PROBE_CNT_W = 11;
    localparam int CFG_W       = 11;
    localparam int APB_DATA_W  = 32;
    localparam int PADDR_W     = 3;

    localparam int STEP_LIN = 3;
    localparam int STEP_SQR = 7;
    // first difference of the probe offset and its constant growth
    localparam int DELTA0 = STEP_LIN + STEP_SQR;
    localparam int DDELTA = 2 * STEP_SQR;

    // key remainder: digit-serial restoring division
    localparam int DIV_DIGIT_W = 4;
    localparam int KEY_PAD_W   = 32;
    localparam int DIV_STEPS   = KEY_PAD_W / DIV_DIGIT_W;

    localparam logic REG_SLOTS_IN_USE = 1'b0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_INSERTED  = 3'd0,
        RES_FOUND     = 3'd1,
        RES_NOT_FOUND = 3'd2,
        RES_FULL      = 3'd3,
        RES_CLEARED   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_DIV,
        S_START,
        S_READ,
        S_CHECK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    load;
        logic    div_step;
        logic    probe_init;
        logic    probe_adv;
        logic    key_wr;
        logic    sweep_start;
        logic    sweep_wr;
        logic    out_load;
        status_t out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
        logic sweep_last;
        logic slot_empty;
        logic key_hit;
        logic last_probe;
        logic out_free;
    } dp_stat_t;

    // DELTA0 mod s, valid for s >= 1
    function automatic logic [3:0] delta0_mod(input logic [31:0] s);
        logic [3:0] r;
        if (s > 32'(DELTA0))
        begin
            r = 4'(DELTA0);
        end
        else
        begin
            unique case (s[3:0])
                4'd3:    r = 4'd1;
                4'd4:    r = 4'd2;
                4'd6:    r = 4'd4;
                4'd7:    r = 4'd3;
                4'd8:    r = 4'd2;
                4'd9:    r = 4'd1;
                default: r = 4'd0;
            endcase
        end
        return r;
    endfunction

    // DDELTA mod s, valid for s >= 1
    function automatic logic [3:0] ddelta_mod(input logic [31:0] s);
        logic [3:0] r;
        if (s > 32'(DDELTA))
        begin
            r = 4'(DDELTA);
        end
        else
        begin
            unique case (s[3:0])
                4'd3:    r = 4'd2;
                4'd4:    r = 4'd2;
                4'd5:    r = 4'd4;
                4'd6:    r = 4'd2;
                4'd8:    r = 4'd6;
                4'd9:    r = 4'd5;
                4'd10:   r = 4'd4;
                4'd11:   r = 4'd3;
                4'd12:   r = 4'd2;
                4'd13:   r = 4'd1;
                default: r = 4'd0;
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/qpht_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_if
// Request and result channels of the hash table, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qpht_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [qpht_pkg::ACTION_W-1:0] action;
    logic [qpht_pkg::KEY_W-1:0]    key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

interface qpht_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [qpht_pkg::STATUS_W-1:0]    status;
    logic [qpht_pkg::SLOT_IDX_W-1:0]  slot_index;
    logic [qpht_pkg::PROBE_CNT_W-1:0] probe_count;

    modport source (output valid, output status, output slot_index, output probe_count,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input probe_count,
                    output ready);
endinterface
`default_nettype wire

[rtl/qpht_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_ram
// Generic memory, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module qpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = qpht_pkg::DEF_TABLE_SLOTS
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/qpht_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_dp
// Datapath: key remainder, probe position stepping, slot memory and result
// register.
// ----------------------------------------------------------------------------
module qpht_dp #(
    parameter int TABLE_SLOTS = qpht_pkg::DEF_TABLE_SLOTS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire qpht_pkg::dp_cmd_t                   ctl,
    output qpht_pkg::dp_stat_t                       sts,
    input  wire logic [qpht_pkg::CFG_W-1:0]          slots_in_use,
    input  wire logic [qpht_pkg::KEY_W-1:0]          key,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [qpht_pkg::STATUS_W-1:0]       status,
    output logic      [qpht_pkg::SLOT_IDX_W-1:0]     slot_index,
    output logic      [qpht_pkg::PROBE_CNT_W-1:0]    probe_count
);

    localparam int IW    = $clog2(TABLE_SLOTS);
    localparam int CW    = IW + 1;
    localparam int DCW   = $clog2(qpht_pkg::DIV_STEPS);
    localparam int MEM_W = qpht_pkg::KEY_W + 1;

    logic [CW-1:0]                  s_reg, s_next;
    logic [qpht_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [qpht_pkg::KEY_PAD_W-1:0] shf_reg, shf_next;
    logic [CW-1:0]                  rem_reg, rem_next;
    logic [DCW-1:0]                 div_cnt_reg, div_cnt_next;
    logic [IW-1:0]                  pos_reg, pos_next;
    logic [IW-1:0]                  delta_reg, delta_next;
    logic [IW-1:0]                  step_reg, step_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [IW-1:0]                  sweep_reg, sweep_next;
    logic                           out_valid_reg, out_valid_next;
    logic [qpht_pkg::STATUS_W-1:0]    out_status_reg;
    logic [qpht_pkg::SLOT_IDX_W-1:0]  out_slot_reg;
    logic [qpht_pkg::PROBE_CNT_W-1:0] out_count_reg;

    logic [CW-1:0]      s_clamp;
    logic [CW-1:0]      div_rem;
    logic [CW:0]        div_t;
    logic [CW-1:0]      pos_sum, pos_wrap;
    logic [CW-1:0]      delta_sum, delta_wrap;
    logic [CW-1:0]      cnt_inc;
    logic [31:0]        pos_wide, cnt_wide;
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [MEM_W-1:0]   mem_wdata, mem_rdata;
    logic               rd_used;

    // slot count of zero means one, above the table size it saturates
    always_comb
    begin
        if (slots_in_use == '0)
        begin
            s_clamp = CW'(1);
        end
        else if (32'(slots_in_use) > 32'(TABLE_SLOTS))
        begin
            s_clamp = CW'(TABLE_SLOTS);
        end
        else
        begin
            s_clamp = CW'(slots_in_use);
        end
    end

    // one remainder digit per cycle, msb first
    always_comb
    begin
        div_rem = rem_reg;
        div_t   = '0;
        for (int d = 0; d < qpht_pkg::DIV_DIGIT_W; d++)
        begin
            div_t = {div_rem, shf_reg[qpht_pkg::KEY_PAD_W-1-d]};
            if (div_t >= {1'b0, s_reg})
            begin
                div_t = div_t - {1'b0, s_reg};
            end
            div_rem = div_t[CW-1:0];
        end
    end

    // next probe: pos += delta, delta += ddelta, both mod s
    assign pos_sum    = {1'b0, pos_reg} + {1'b0, delta_reg};
    assign pos_wrap   = (pos_sum >= s_reg) ? pos_sum - s_reg : pos_sum;
    assign delta_sum  = {1'b0, delta_reg} + {1'b0, step_reg};
    assign delta_wrap = (delta_sum >= s_reg) ? delta_sum - s_reg : delta_sum;
    assign cnt_inc    = cnt_reg + CW'(1);

    always_comb
    begin
        s_next       = s_reg;
        key_next     = key_reg;
        shf_next     = shf_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        pos_next     = pos_reg;
        delta_next   = delta_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        if (ctl.load)
        begin
            s_next       = s_clamp;
            key_next     = key;
            shf_next     = qpht_pkg::KEY_PAD_W'(key);
            rem_next     = '0;
            div_cnt_next = '0;
        end
        if (ctl.div_step)
        begin
            shf_next     = shf_reg << qpht_pkg::DIV_DIGIT_W;
            rem_next     = div_rem;
            div_cnt_next = div_cnt_reg + DCW'(1);
        end
        if (ctl.probe_init)
        begin
            pos_next   = rem_reg[IW-1:0];
            delta_next = IW'(qpht_pkg::delta0_mod(32'(s_reg)));
            step_next  = IW'(qpht_pkg::ddelta_mod(32'(s_reg)));
            cnt_next   = '0;
        end
        if (ctl.probe_adv)
        begin
            pos_next   = pos_wrap[IW-1:0];
            delta_next = delta_wrap[IW-1:0];
            cnt_next   = cnt_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg       <= s_next;
        key_reg     <= key_next;
        shf_reg     <= shf_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        pos_reg     <= pos_next;
        delta_reg   <= delta_next;
        step_reg    <= step_next;
        cnt_reg     <= cnt_next;
    end

    // clearing sweep over every slot, also right after reset
    always_comb
    begin
        sweep_next = sweep_reg;
        if (ctl.sweep_start)
        begin
            sweep_next = '0;
        end
        else if (ctl.sweep_wr)
        begin
            sweep_next = sweep_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // slot memory entry: {used, key}
    assign mem_we    = ctl.key_wr | ctl.sweep_wr;
    assign mem_waddr = ctl.sweep_wr ? sweep_reg : pos_reg;
    assign mem_wdata = ctl.sweep_wr ? '0 : {1'b1, key_reg};

    qpht_ram #(
        .WIDTH (MEM_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (pos_reg),
        .rdata (mem_rdata)
    );

    assign rd_used = mem_rdata[qpht_pkg::KEY_W];

    // result register
    assign pos_wide = 32'(pos_reg);
    assign cnt_wide = 32'(cnt_inc);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_status_reg <= ctl.out_status;
            if (ctl.out_status == qpht_pkg::RES_INSERTED ||
                ctl.out_status == qpht_pkg::RES_FOUND)
            begin
                out_slot_reg <= pos_wide[qpht_pkg::SLOT_IDX_W-1:0];
            end
            else
            begin
                out_slot_reg <= '0;
            end
            if (ctl.out_status == qpht_pkg::RES_CLEARED)
            begin
                out_count_reg <= '0;
            end
            else
            begin
                out_count_reg <= cnt_wide[qpht_pkg::PROBE_CNT_W-1:0];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign slot_index  = out_slot_reg;
    assign probe_count = out_count_reg;

    assign sts.div_last   = (div_cnt_reg == DCW'(qpht_pkg::DIV_STEPS - 1));
    assign sts.sweep_last = (sweep_reg == IW'(TABLE_SLOTS - 1));
    assign sts.slot_empty = !rd_used;
    assign sts.key_hit    = rd_used && (mem_rdata[qpht_pkg::KEY_W-1:0] == key_reg);
    assign sts.last_probe = (cnt_inc == s_reg);
    assign sts.out_free   = !out_valid_reg || out_ready;

endmodule
`default_nettype wire

[rtl/qpht_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_ctrl
// Controller: sequences remainder, probing, clearing sweep and result
// hand-off.
// ----------------------------------------------------------------------------
module qpht_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    input  wire logic [qpht_pkg::ACTION_W-1:0]   cmd_action,
    output logic                                 cmd_ready,
    output qpht_pkg::dp_cmd_t                    ctl,
    input  wire qpht_pkg::dp_stat_t              sts
);

    qpht_pkg::state_t  state_reg, state_next;
    qpht_pkg::action_t op_reg, op_next;
    qpht_pkg::status_t res_reg, res_next;
    logic              report_reg, report_next;
    logic              accept;

    assign cmd_ready = (state_reg == qpht_pkg::S_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= qpht_pkg::S_SWEEP;
            op_reg     <= qpht_pkg::ACT_NONE;
            res_reg    <= qpht_pkg::RES_CLEARED;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            res_reg    <= res_next;
            report_reg <= report_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        res_next    = res_reg;
        report_next = report_reg;

        ctl.load        = 1'b0;
        ctl.div_step    = 1'b0;
        ctl.probe_init  = 1'b0;
        ctl.probe_adv   = 1'b0;
        ctl.key_wr      = 1'b0;
        ctl.sweep_start = 1'b0;
        ctl.sweep_wr    = 1'b0;
        ctl.out_load    = 1'b0;
        ctl.out_status  = res_reg;

        unique case (state_reg)
            qpht_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (qpht_pkg::action_t'(cmd_action))
                        qpht_pkg::ACT_INSERT,
                        qpht_pkg::ACT_SEARCH:
                        begin
                            ctl.load   = 1'b1;
                            op_next    = qpht_pkg::action_t'(cmd_action);
                            state_next = qpht_pkg::S_DIV;
                        end
                        qpht_pkg::ACT_CLEAR:
                        begin
                            ctl.sweep_start = 1'b1;
                            report_next     = 1'b1;
                            state_next      = qpht_pkg::S_SWEEP;
                        end
                        qpht_pkg::ACT_NONE:
                        begin
                            state_next = qpht_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            qpht_pkg::S_SWEEP:
            begin
                ctl.sweep_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    report_next = 1'b0;
                    res_next    = qpht_pkg::RES_CLEARED;
                    state_next  = report_reg ? qpht_pkg::S_FINISH : qpht_pkg::S_IDLE;
                end
            end
            qpht_pkg::S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = qpht_pkg::S_START;
                end
            end
            qpht_pkg::S_START:
            begin
                ctl.probe_init = 1'b1;
                state_next     = qpht_pkg::S_READ;
            end
            qpht_pkg::S_READ:
            begin
                state_next = qpht_pkg::S_CHECK;
            end
            qpht_pkg::S_CHECK:
            begin
                if (op_reg == qpht_pkg::ACT_INSERT)
                begin
                    priority if (sts.slot_empty)
                    begin
                        ctl.key_wr = 1'b1;
                        res_next   = qpht_pkg::RES_INSERTED;
                        state_next = qpht_pkg::S_FINISH;
                    end
                    else if (sts.last_probe)
                    begin
                        res_next   = qpht_pkg::RES_FULL;
                        state_next = qpht_pkg::S_FINISH;
                    end
                    else
                    begin
                        ctl.probe_adv = 1'b1;
                        state_next    = qpht_pkg::S_READ;
                    end
                end
                else
                begin
                    priority if (sts.key_hit)
                    begin
                        res_next   = qpht_pkg::RES_FOUND;
                        state_next = qpht_pkg::S_FINISH;
                    end
                    else if (sts.slot_empty || sts.last_probe)
                    begin
                        res_next   = qpht_pkg::RES_NOT_FOUND;
                        state_next = qpht_pkg::S_FINISH;
                    end
                    else
                    begin
                        ctl.probe_adv = 1'b1;
                        state_next    = qpht_pkg::S_READ;
                    end
                end
            end
            qpht_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = qpht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = qpht_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/quadratic_probe_hash_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing hash table of keys with quadratic probing and an APB
// register for the number of slots in use.
// ----------------------------------------------------------------------------
// latency of insert or search comes from the remainder digit steps, the probe
//   start, a slot read and a check per probe and the result load; one request at a time
// the separate read and check per probe come from the registered read of the slot memory
// clear: a sweep of one slot per cycle over every slot, then the result is loaded
// after reset the same sweep runs over every slot with no request taken
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table #(
    parameter int TABLE_SLOTS = qpht_pkg::DEF_TABLE_SLOTS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [qpht_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [qpht_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [qpht_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    qpht_cmd_if.sink                               cmd,
    qpht_rsp_if.source                             rsp
);

    localparam int CFG_MAX   = (1 << qpht_pkg::CFG_W) - 1;
    localparam int CFG_RESET = (TABLE_SLOTS > CFG_MAX) ? CFG_MAX : TABLE_SLOTS;

    logic [qpht_pkg::CFG_W-1:0] slots_in_use_reg, slots_in_use_next;
    logic                       cfg_wr;
    qpht_pkg::dp_cmd_t          dp_ctl;
    qpht_pkg::dp_stat_t         dp_sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == qpht_pkg::REG_SLOTS_IN_USE);

    always_comb
    begin
        slots_in_use_next = slots_in_use_reg;
        if (cfg_wr)
        begin
            slots_in_use_next = pwdata[qpht_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= qpht_pkg::CFG_W'(CFG_RESET);
        end
        else
        begin
            slots_in_use_reg <= slots_in_use_next;
        end
    end

    always_comb
    begin
        if (paddr[2] == qpht_pkg::REG_SLOTS_IN_USE)
        begin
            prdata = qpht_pkg::APB_DATA_W'(slots_in_use_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    qpht_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_action (cmd.action),
        .cmd_ready  (cmd.ready),
        .ctl        (dp_ctl),
        .sts        (dp_sts)
    );

    qpht_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (dp_ctl),
        .sts          (dp_sts),
        .slots_in_use (slots_in_use_reg),
        .key          (cmd.key),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .status       (rsp.status),
        .slot_index   (rsp.slot_index),
        .probe_count  (rsp.probe_count)
    );

`ifndef SYNTHESIS
    // a real request keeps the block busy for at least the next cycle
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready &&
         (qpht_pkg::action_t'(cmd.action) != qpht_pkg::ACT_NONE)) |=> !cmd.ready)
        else $error("request taken while a previous one is in flight");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(dp_ctl.key_wr && dp_ctl.sweep_wr))
        else $error("key write collides with clearing sweep");

    a_insert_empty_only: assert property (@(posedge clk) disable iff (!rst_n)
        dp_ctl.key_wr |-> dp_sts.slot_empty)
        else $error("insert overwrites an occupied slot");

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        dp_ctl.out_load |-> dp_sts.out_free)
        else $error("result register overwritten before it was taken");
`endif

endmodule
`default_nettype wire
